>>> src/acpr_pkg.sv
package acpr_pkg;

    localparam int ENTRIES = 16;
    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              clean;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_VREAD,
        S_VCAP,
        S_RESULT
    } state_t;

endpackage

>>> src/acpr_store.sv
module acpr_store (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [acpr_pkg::IDX_W-1:0] wr_idx,
    input  acpr_pkg::slot_t           wr_entry,
    input  logic                      rd_en,
    input  logic [acpr_pkg::IDX_W-1:0] rd_idx,
    output acpr_pkg::slot_t           rd_entry
);
    import acpr_pkg::*;

    slot_t mem [ENTRIES];
    slot_t rd_entry_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= mem[rd_idx];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

>>> src/assoc_cache_parity_replacement_top.sv
// Channel   Ports                                    Direction  Transaction
// input     s_valid s_ready s_func s_address s_payload  in      one lookup/put/write
// result    m_valid m_ready m_hit m_read_data m_evicted  out     one result per input
//           m_victim_address m_victim_data m_victim_clean
//
// Sequence: a read or a hit-free fill scans the N slots in use (a hit in slot i ends the
// scan there); a fill that evicts then reads and captures the victim. The store's single
// read port compares one slot per cycle. A no-op code skips the scan.
// Reset: aresetn synchronous, active low; empties the cache, slot contents are not cleared.
// Stalls: s_ready is high only between transactions; a held result in the output
// register does not block acceptance, only the final hand-off.
module assoc_cache_parity_replacement_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [acpr_pkg::FUNC_W-1:0] s_func,
    input  logic [acpr_pkg::ADDR_W-1:0] s_address,
    input  logic [acpr_pkg::DATA_W-1:0] s_payload,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [acpr_pkg::DATA_W-1:0] m_read_data,
    output logic                        m_evicted,
    output logic [acpr_pkg::ADDR_W-1:0] m_victim_address,
    output logic [acpr_pkg::DATA_W-1:0] m_victim_data,
    output logic                        m_victim_clean
);
    import acpr_pkg::*;

    state_t             state_reg, state_next;
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [DATA_W-1:0]  data_reg, data_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   victim_reg, victim_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [IDX_W-1:0]   oldest_reg, oldest_next;

    logic               res_hit_reg, res_hit_next;
    logic [DATA_W-1:0]  res_rdata_reg, res_rdata_next;
    logic               res_evicted_reg, res_evicted_next;
    logic [ADDR_W-1:0]  res_vaddr_reg, res_vaddr_next;
    logic [DATA_W-1:0]  res_vdata_reg, res_vdata_next;
    logic               res_vclean_reg, res_vclean_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic [DATA_W-1:0]  out_rdata_reg, out_rdata_next;
    logic               out_evicted_reg, out_evicted_next;
    logic [ADDR_W-1:0]  out_vaddr_reg, out_vaddr_next;
    logic [DATA_W-1:0]  out_vdata_reg, out_vdata_next;
    logic               out_vclean_reg, out_vclean_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    slot_t              wr_entry;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    slot_t              rd_entry;

    logic               issue;
    logic               match;
    logic               is_read;
    logic               is_clean;

    acpr_store u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry)
    );

    assign issue    = (rd_idx_reg < fill_reg);
    assign match    = cmp_valid_reg && (rd_entry.addr == addr_reg);
    assign is_read  = (func_reg == FUNC_READ);
    assign is_clean = (func_reg == FUNC_PUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg        <= func_next;
        addr_reg        <= addr_next;
        data_reg        <= data_next;
        rd_idx_reg      <= rd_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        victim_reg      <= victim_next;
        res_hit_reg     <= res_hit_next;
        res_rdata_reg   <= res_rdata_next;
        res_evicted_reg <= res_evicted_next;
        res_vaddr_reg   <= res_vaddr_next;
        res_vdata_reg   <= res_vdata_next;
        res_vclean_reg  <= res_vclean_next;
        out_hit_reg     <= out_hit_next;
        out_rdata_reg   <= out_rdata_next;
        out_evicted_reg <= out_evicted_next;
        out_vaddr_reg   <= out_vaddr_next;
        out_vdata_reg   <= out_vdata_next;
        out_vclean_reg  <= out_vclean_next;
    end

    always_comb begin
        state_next       = state_reg;
        func_next        = func_reg;
        addr_next        = addr_reg;
        data_next        = data_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        victim_next      = victim_reg;
        fill_next        = fill_reg;
        oldest_next      = oldest_reg;
        res_hit_next     = res_hit_reg;
        res_rdata_next   = res_rdata_reg;
        res_evicted_next = res_evicted_reg;
        res_vaddr_next   = res_vaddr_reg;
        res_vdata_next   = res_vdata_reg;
        res_vclean_next  = res_vclean_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_hit_next     = out_hit_reg;
        out_rdata_next   = out_rdata_reg;
        out_evicted_next = out_evicted_reg;
        out_vaddr_next   = out_vaddr_reg;
        out_vdata_next   = out_vdata_reg;
        out_vclean_next  = out_vclean_reg;
        wr_en            = 1'b0;
        wr_idx           = cmp_idx_reg;
        wr_entry         = '{addr: addr_reg, data: data_reg, clean: is_clean};
        rd_en            = 1'b0;
        rd_idx           = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next        = s_func;
                    addr_next        = s_address;
                    data_next        = s_payload;
                    rd_idx_next      = '0;
                    res_hit_next     = 1'b0;
                    res_rdata_next   = '0;
                    res_evicted_next = 1'b0;
                    res_vaddr_next   = '0;
                    res_vdata_next   = '0;
                    res_vclean_next  = 1'b0;
                    state_next       = (s_func == FUNC_NOP) ? S_RESULT : S_SCAN;
                end
            end
            S_SCAN: begin
                // one read in flight; compare the slot fetched last cycle
                rd_en          = issue;
                cmp_valid_next = issue;
                cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                if (issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (match) begin
                    res_hit_next = 1'b1;
                    if (is_read) begin
                        res_rdata_next = rd_entry.data;
                    end else begin
                        wr_en  = 1'b1;
                        wr_idx = cmp_idx_reg;
                    end
                    state_next = S_RESULT;
                end else if (!issue) begin
                    if (is_read) begin
                        state_next = S_RESULT;
                    end else if (fill_reg < CNT_W'(ENTRIES)) begin
                        wr_en      = 1'b1;
                        wr_idx     = fill_reg[IDX_W-1:0];
                        fill_next  = fill_reg + 1'b1;
                        state_next = S_RESULT;
                    end else begin
                        if (!addr_reg[0]) begin
                            victim_next = oldest_reg;
                        end else if (oldest_reg == '0) begin
                            victim_next = IDX_W'(ENTRIES - 1);
                        end else begin
                            victim_next = oldest_reg - 1'b1;
                        end
                        state_next = S_VREAD;
                    end
                end
            end
            S_VREAD: begin
                rd_en  = 1'b1;
                rd_idx = victim_reg;
                if (!addr_reg[0]) begin
                    oldest_next = (oldest_reg == IDX_W'(ENTRIES - 1)) ? '0
                                                                      : oldest_reg + 1'b1;
                end
                state_next = S_VCAP;
            end
            S_VCAP: begin
                res_evicted_next = 1'b1;
                res_vaddr_next   = rd_entry.addr;
                res_vdata_next   = rd_entry.data;
                res_vclean_next  = rd_entry.clean;
                wr_en            = 1'b1;
                wr_idx           = victim_reg;
                state_next       = S_RESULT;
            end
            S_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next   = 1'b1;
                    out_hit_next     = res_hit_reg;
                    out_rdata_next   = res_rdata_reg;
                    out_evicted_next = res_evicted_reg;
                    out_vaddr_next   = res_vaddr_reg;
                    out_vdata_next   = res_vdata_reg;
                    out_vclean_next  = res_vclean_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = out_valid_reg;
    assign m_hit            = out_hit_reg;
    assign m_read_data      = out_rdata_reg;
    assign m_evicted        = out_evicted_reg;
    assign m_victim_address = out_vaddr_reg;
    assign m_victim_data    = out_vdata_reg;
    assign m_victim_clean   = out_vclean_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond capacity");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(fill_reg) |-> fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count moved by other than one");

    a_oldest_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(oldest_reg) |-> $past(fill_reg) == CNT_W'(ENTRIES))
        else $error("oldest pointer moved before cache full");

    a_oldest_range: assert property (@(posedge aclk) disable iff (!aresetn)
        oldest_reg <= IDX_W'(ENTRIES - 1))
        else $error("oldest pointer out of range");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_RESULT))
        else $error("result raised outside result state");

endmodule
